/* rtl/crc16me_pkg.sv */
`timescale 1ns / 1ps

package crc16me_pkg;

    localparam logic [1:0] MODE_REFLECTED = 2'd0;
    localparam logic [1:0] MODE_CCITT     = 2'd1;
    localparam logic [1:0] MODE_VARIANT   = 2'd2;

    localparam logic [15:0] POLY_REFLECTED = 16'hA001;
    localparam logic [15:0] POLY_CCITT     = 16'h1021;
    localparam logic [15:0] POLY_VARIANT   = 16'h8005;

    localparam logic REG_CRC_MODE   = 1'b0;
    localparam logic REG_INIT_VALUE = 1'b1;

    typedef struct packed {
        logic [1:0]  crc_mode;
        logic [15:0] init_value;
    } crc_cfg_t;

    function automatic logic [15:0] crc_reflected(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ POLY_REFLECTED;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = (c << 1) ^ POLY_CCITT;
            else
                c = c << 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_variant(input logic [15:0] crc, input logic [7:0] b,
                                                input logic [7:0] prev);
        logic [15:0] c;
        if (crc[15])
            c = (crc << 1) ^ POLY_VARIANT;
        else
            c = crc << 1;
        return c ^ {prev, b};
    endfunction

endpackage

/* rtl/crc16me_apb_regs.sv */
`timescale 1ns / 1ps

module crc16me_apb_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output crc16me_pkg::crc_cfg_t cfg
);
    import crc16me_pkg::*;

    logic [1:0]  crc_mode_reg;
    logic [15:0] init_value_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg   <= MODE_REFLECTED;
            init_value_reg <= 16'h0000;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CRC_MODE:   crc_mode_reg   <= pwdata[1:0];
                REG_INIT_VALUE: init_value_reg <= pwdata[15:0];
                default:        crc_mode_reg   <= crc_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CRC_MODE:   prdata = {30'd0, crc_mode_reg};
            REG_INIT_VALUE: prdata = {16'd0, init_value_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.crc_mode   = crc_mode_reg;
    assign cfg.init_value = init_value_reg;

endmodule

/* rtl/crc16me_update.sv */
`timescale 1ns / 1ps

module crc16me_update (
    input  logic [1:0]  crc_mode,
    input  logic [15:0] crc_in,
    input  logic [7:0]  byte_in,
    input  logic [7:0]  prev_byte,
    output logic [15:0] crc_out,
    output logic [15:0] crc_final
);
    import crc16me_pkg::*;

    always_comb
    begin
        unique case (crc_mode)
            MODE_CCITT:   crc_out = crc_ccitt(crc_in, byte_in);
            MODE_VARIANT: crc_out = crc_variant(crc_in, byte_in, prev_byte);
            default:      crc_out = crc_reflected(crc_in, byte_in);
        endcase
    end

    // variant mode hands the result out with its bytes swapped
    assign crc_final = (crc_mode == MODE_VARIANT) ? {crc_out[7:0], crc_out[15:8]} : crc_out;

endmodule

/* rtl/crc16_multimode_engine.sv */
`timescale 1ns / 1ps
// a frame's last byte is held in the input stage, then its result in out_data_reg (m_tdata)
// throughput: one byte per cycle unless stalled, set by the loop through the running crc_reg
// a result waiting on m_tready stalls the input only when the next queued byte also ends a frame
// reset (rst_n, asynchronous, active low) empties both stages, clears running crc and
// previous byte to zero and sets crc_mode and init_value to zero
module crc16_multimode_engine (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tuser,    // [0] frame_start
    input  logic        s_tlast,    // frame_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] crc_result
);
    import crc16me_pkg::*;

    crc_cfg_t    cfg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        in_last_reg;

    logic [15:0] crc_reg;
    logic [7:0]  prev_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic        advance;
    logic        s_accept;
    logic [15:0] base_crc;
    logic [7:0]  base_prev;
    logic [15:0] crc_next;
    logic [15:0] crc_final;

    crc16me_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame start reloads the crc and forgets the previous byte
    assign base_crc  = in_start_reg ? cfg.init_value : crc_reg;
    assign base_prev = in_start_reg ? 8'h00 : prev_reg;

    crc16me_update u_update (
        .crc_mode  (cfg.crc_mode),
        .crc_in    (base_crc),
        .byte_in   (in_byte_reg),
        .prev_byte (base_prev),
        .crc_out   (crc_next),
        .crc_final (crc_final)
    );

    // a byte that makes no result never waits on the output side
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= 16'h0000;
            prev_reg <= 8'h00;
        end
        else if (advance)
        begin
            crc_reg  <= crc_next;
            prev_reg <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_data_reg <= crc_final;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input stage only refuses a request while it holds a byte
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stage refused a request while empty");

    // a frame end always lands in the result register
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> m_tvalid)
        else $error("frame end did not produce a result");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

endmodule
